FILE: rtl/bwlp_pkg.sv
`timescale 1ns / 1ps

package bwlp_pkg;

    localparam int SAMPLE_BITS         = 16;
    localparam int COEF_BITS           = 20;
    localparam int COEF_FRAC_BITS_DEF  = 16;
    localparam int CFG_IDX_BITS        = 3;

    // products are COEF_BITS + SAMPLE_BITS wide; five of them plus a rounding half
    localparam int ACC_BITS = SAMPLE_BITS + COEF_BITS + 3;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_B0 = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_B1 = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_B2 = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_A1 = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_A2 = 3'd4;

    // coefficient reset values, Q3.16
    localparam logic signed [COEF_BITS-1:0] B0_RESET = 20'sd65536;
    localparam logic signed [COEF_BITS-1:0] COEF_ZERO = '0;

    // warm-up counter codes
    localparam logic [1:0] WARM_DONE = 2'd0;
    localparam logic [1:0] WARM_ONE  = 2'd1;
    localparam logic [1:0] WARM_TWO  = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          restart;
    } t_in_beat;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          saturated;
    } t_out_beat;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] b0;
        logic signed [COEF_BITS-1:0] b1;
        logic signed [COEF_BITS-1:0] b2;
        logic signed [COEF_BITS-1:0] a1;
        logic signed [COEF_BITS-1:0] a2;
    } t_coefs;

endpackage

FILE: rtl/butterworth_lowpass_biquad.sv
`timescale 1ns / 1ps

// Second-order low-pass biquad, direct form I, one sample per beat.
// Input channel: i_in_valid / o_in_stall carrying t_in_beat (sample, restart).
// Output channel: o_out_valid / i_out_stall carrying t_out_beat (sample, sat flag).
// Config channel: i_cfg_valid / o_cfg_ready, index 0..4 = b0 b1 b2 a1 a2,
// signed Q3.16 and already scaled by 1/a0; other indexes are ignored.
// Write coefficients only while the filter is idle.
// Registered path: input register, then result register.
// Throughput: one beat per cycle unless the output stalls. The multiply-add for a
// sample and the history update share a cycle, since y1 feeds straight back.
// Reset (synchronous, active low): b0 = 1.0, rest 0, history cleared and the
// two-sample pass-through armed; o_in_stall reads high and o_cfg_ready low in reset.
// A stalled output holds its beat; the input register still takes one more
// beat, then o_in_stall rises until the result register drains.
// restart on a beat clears history before that sample and rearms warm-up.
module butterworth_lowpass_biquad
    import bwlp_pkg::*;
#(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // sample in
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  t_in_beat                i_in_data,
    // sample out
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output t_out_beat               o_out_data,
    // coefficient writes
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [COEF_BITS-1:0]    i_cfg_data
);

    logic      r_in_valid;
    t_in_beat  r_in;
    logic      r_out_valid;
    t_out_beat r_out;

    logic      in_take;
    logic      fire;    // input register moves into the result register
    t_coefs    coefs;
    t_out_beat result;

    assign fire    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign in_take = i_in_valid && !o_in_stall;

    assign o_in_stall  = !i_rst_n || (r_in_valid && !fire);
    assign o_cfg_ready = i_rst_n;

    bwlp_coef_regs #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_coefs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_idx   (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_coefs (coefs)
    );

    bwlp_core #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_beat  (r_in),
        .i_coefs (coefs),
        .o_beat  (result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/bwlp_coef_regs.sv
`timescale 1ns / 1ps

module bwlp_coef_regs
    import bwlp_pkg::*;
#(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_wr,
    input  logic [CFG_IDX_BITS-1:0]   i_idx,
    input  logic [COEF_BITS-1:0]      i_data,
    output t_coefs                    o_coefs
);

    // unity gain at the chosen fraction width
    localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(64'd1 << COEF_FRAC_BITS);

    t_coefs r_coefs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.b0 <= COEF_ONE;
            r_coefs.b1 <= COEF_ZERO;
            r_coefs.b2 <= COEF_ZERO;
            r_coefs.a1 <= COEF_ZERO;
            r_coefs.a2 <= COEF_ZERO;
        end else if (i_wr) begin
            unique case (i_idx)
                REG_B0:  r_coefs.b0 <= i_data;
                REG_B1:  r_coefs.b1 <= i_data;
                REG_B2:  r_coefs.b2 <= i_data;
                REG_A1:  r_coefs.a1 <= i_data;
                REG_A2:  r_coefs.a2 <= i_data;
                default: ; // unmapped index, write dropped
            endcase
        end
    end

    assign o_coefs = r_coefs;

endmodule

FILE: rtl/bwlp_core.sv
`timescale 1ns / 1ps

module bwlp_core
    import bwlp_pkg::*;
#(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_beat  i_beat,
    input  t_coefs    i_coefs,
    output t_out_beat o_beat
);

    localparam int PROD_BITS = COEF_BITS + SAMPLE_BITS;
    localparam logic signed [ACC_BITS-1:0] ROUND_HALF =
        ACC_BITS'(64'd1 << (COEF_FRAC_BITS - 1));
    localparam logic signed [ACC_BITS-1:0] LIM_HI = ACC_BITS'(SAMPLE_MAX);
    localparam logic signed [ACC_BITS-1:0] LIM_LO = ACC_BITS'(SAMPLE_MIN);

    // direct form I history
    logic signed [SAMPLE_BITS-1:0] r_x1, r_x2, r_y1, r_y2;
    logic signed [SAMPLE_BITS-1:0] n_x1, n_x2, n_y1, n_y2;
    logic [1:0]                    r_warm, n_warm;

    logic [1:0]                    warm;
    logic signed [SAMPLE_BITS-1:0] x;
    logic signed [PROD_BITS-1:0]   p_b0, p_b1, p_b2, p_a1, p_a2;
    logic signed [ACC_BITS-1:0]    acc, acc_q;
    logic signed [SAMPLE_BITS-1:0] y;
    logic                          sat;

    assign x    = i_beat.sample_in;
    assign warm = i_beat.restart ? WARM_TWO : r_warm;

    assign p_b0 = i_coefs.b0 * x;
    assign p_b1 = i_coefs.b1 * r_x1;
    assign p_b2 = i_coefs.b2 * r_x2;
    assign p_a1 = i_coefs.a1 * r_y1;
    assign p_a2 = i_coefs.a2 * r_y2;

    assign acc = ACC_BITS'(p_b0) + ACC_BITS'(p_b1) + ACC_BITS'(p_b2)
               - ACC_BITS'(p_a1) - ACC_BITS'(p_a2) + ROUND_HALF;
    assign acc_q = acc >>> COEF_FRAC_BITS;   // floor after adding a half

    always_comb begin
        n_warm = r_warm;
        n_x1   = r_x1;
        n_x2   = r_x2;
        n_y1   = r_y1;
        n_y2   = r_y2;
        y      = x;
        sat    = 1'b0;
        if (warm >= WARM_TWO) begin
            // first warm-up sample seeds the history
            n_warm = WARM_ONE;
            n_x1   = x;
            n_x2   = '0;
            n_y1   = x;
            n_y2   = '0;
        end else if (warm == WARM_ONE) begin
            n_warm = WARM_DONE;
            n_x1   = x;
            n_x2   = r_x1;
            n_y1   = x;
            n_y2   = r_y1;
        end else begin
            if (acc_q > LIM_HI) begin
                y   = SAMPLE_MAX;
                sat = 1'b1;
            end else if (acc_q < LIM_LO) begin
                y   = SAMPLE_MIN;
                sat = 1'b1;
            end else begin
                y   = acc_q[SAMPLE_BITS-1:0];
            end
            n_x1 = x;
            n_x2 = r_x1;
            n_y1 = y;
            n_y2 = r_y1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warm <= WARM_TWO;
            r_x1   <= '0;
            r_x2   <= '0;
            r_y1   <= '0;
            r_y2   <= '0;
        end else if (i_fire) begin
            r_warm <= n_warm;
            r_x1   <= n_x1;
            r_x2   <= n_x2;
            r_y1   <= n_y1;
            r_y2   <= n_y2;
        end
    end

    assign o_beat.sample_out = y;
    assign o_beat.saturated  = sat;

endmodule

FILE: rtl/bwlp_checker.sv
`timescale 1ns / 1ps

module bwlp_checker
    import bwlp_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_beat o_out_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed under stall");

    // nothing comes out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

    // an empty result register never back-pressures the input
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with result register empty");

    // a clipped result sits on a rail
    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.saturated |->
            o_out_data.sample_out == SAMPLE_MAX || o_out_data.sample_out == SAMPLE_MIN)
        else $error("saturated flag without a rail value");

endmodule

bind butterworth_lowpass_biquad bwlp_checker u_bwlp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

FILE: tb/butterworth_lowpass_biquad_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the direct form I low-pass biquad.
// A predictor tracks history, warm-up and coefficients and builds the expected output
// beat as each input beat is accepted. The output side compares every beat against
// the oldest prediction. The sender works in bursts and the receiver stalls on a
// pattern of its own.
module butterworth_lowpass_biquad_tb;
    import bwlp_pkg::*;

    localparam int  NUM_COEFS    = 5;
    localparam int  CFG_SLOTS    = 1 << CFG_IDX_BITS;
    localparam int  FRAC         = COEF_FRAC_BITS_DEF;
    localparam int  DRAIN_CYCLES = 4;          // input and result registers plus margin
    localparam int  CYCLE_LIMIT  = 300000;
    localparam int  RANDOM_SETS  = 6;
    localparam int  SET_BEATS    = 200;
    localparam real PI           = 3.14159265358979;

    // DUT ports; every input starts at a known value
    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_in_valid  = 1'b0;
    logic                    o_in_stall;
    t_in_beat                i_in_data   = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b1;
    t_out_beat               o_out_data;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [COEF_BITS-1:0]    i_cfg_data  = '0;

    // predictor state: coefficients and filter history
    logic signed [COEF_BITS-1:0]   filt_coef [NUM_COEFS];
    logic signed [SAMPLE_BITS-1:0] hist_x1, hist_x2, hist_y1, hist_y2;
    logic [1:0]                    warm_left;

    // output beats still owed by the filter, oldest first
    t_out_beat predicted_outputs [$];

    int err_count     = 0;
    int beats_sent    = 0;
    int beats_checked = 0;
    int clipped_seen  = 0;
    int restarts_sent = 0;
    int sets_loaded   = 0;
    int cycles        = 0;

    // sender burst state
    int burst_left = 0;

    // receiver stall pattern
    int stall_run = 0;
    bit stall_on  = 1'b1;

    butterworth_lowpass_biquad dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Hard stop if the handshakes ever hang.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still owed",
                     cycles, predicted_outputs.size());
            $display("status: fail");
            $finish;
        end
    end

    // Predict one output beat and advance the history, as the filter does.
    function automatic t_out_beat filter_step(input t_in_beat beat);
        t_out_beat                     res;
        logic signed [SAMPLE_BITS-1:0] x;
        longint                        acc;
        longint                        y;
        x             = beat.sample_in;
        res.saturated = 1'b0;
        if (beat.restart) begin
            hist_x1   = '0;
            hist_x2   = '0;
            hist_y1   = '0;
            hist_y2   = '0;
            warm_left = WARM_TWO;
        end
        if (warm_left == WARM_TWO) begin
            // first warm-up sample seeds x1/y1, clears the older taps
            warm_left      = WARM_ONE;
            hist_x2        = '0;
            hist_y2        = '0;
            hist_x1        = x;
            hist_y1        = x;
            res.sample_out = x;
        end else if (warm_left == WARM_ONE) begin
            warm_left      = WARM_DONE;
            hist_x2        = hist_x1;
            hist_y2        = hist_y1;
            hist_x1        = x;
            hist_y1        = x;
            res.sample_out = x;
        end else begin
            acc = longint'(filt_coef[REG_B0]) * longint'(x)
                + longint'(filt_coef[REG_B1]) * longint'(hist_x1)
                + longint'(filt_coef[REG_B2]) * longint'(hist_x2)
                - longint'(filt_coef[REG_A1]) * longint'(hist_y1)
                - longint'(filt_coef[REG_A2]) * longint'(hist_y2);
            // round half up, then floor via arithmetic shift
            acc = acc + (longint'(1) <<< (FRAC - 1));
            y   = acc >>> FRAC;
            if (y > longint'(SAMPLE_MAX)) begin
                y             = longint'(SAMPLE_MAX);
                res.saturated = 1'b1;
            end else if (y < longint'(SAMPLE_MIN)) begin
                y             = longint'(SAMPLE_MIN);
                res.saturated = 1'b1;
            end
            res.sample_out = y[SAMPLE_BITS-1:0];
            hist_x2        = hist_x1;
            hist_x1        = x;
            hist_y2        = hist_y1;
            hist_y1        = res.sample_out;
        end
        return res;
    endfunction

    // Send one input beat. Bursts of random length, random gaps between them;
    // valid stays high across a burst, so it is never dropped and raised in one step.
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] smp, input logic rs);
        t_in_beat beat;
        int       gap;
        beat.sample_in = smp;
        beat.restart   = rs;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do @(posedge i_clk); while (o_in_stall);
        predicted_outputs.push_back(filter_step(beat));
        beats_sent++;
        if (rs)
            restarts_sent++;
    endtask

    // Close the input stream and let every owed beat come out.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (predicted_outputs.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One config beat; valid is left high for back-to-back writes.
    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [COEF_BITS-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx < NUM_COEFS)
            filt_coef[idx] = val;
    endtask

    task automatic load_coefs(input logic signed [COEF_BITS-1:0] b0, b1, b2, a1, a2);
        wait_idle();
        cfg_write(REG_B0, b0);
        cfg_write(REG_B1, b1);
        cfg_write(REG_B2, b2);
        cfg_write(REG_A1, a1);
        cfg_write(REG_A2, a2);
        i_cfg_valid <= 1'b0;
        sets_loaded++;
    endtask

    function automatic logic signed [COEF_BITS-1:0] to_q16(input real v);
        return COEF_BITS'($rtoi(v * (2.0 ** FRAC) + ((v >= 0.0) ? 0.5 : -0.5)));
    endfunction

    // Bilinear-transform Butterworth design; ratio is cutoff over sample rate.
    task automatic load_butterworth(input real ratio);
        real k, rt2, norm, b0r, a1r, a2r;
        k    = $tan(PI * ratio);
        rt2  = $sqrt(2.0);
        norm = 1.0 / (1.0 + rt2 * k + k * k);
        b0r  = k * k * norm;
        a1r  = 2.0 * (k * k - 1.0) * norm;
        a2r  = (1.0 - rt2 * k + k * k) * norm;
        load_coefs(to_q16(b0r), to_q16(2.0 * b0r), to_q16(b0r), to_q16(a1r), to_q16(a2r));
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
            1, 2:    return SAMPLE_BITS'(int'($urandom_range(0, 511)) - 256);
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    // Reset coefficients (b0 = 1.0): warm-up passes through, then identity.
    task automatic test_warmup_passthrough();
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample('0, 1'b0);
        send_sample(-1, 1'b0);
    endtask

    // Restart mid-stream and on the second warm-up sample.
    task automatic test_restart_midstream();
        send_sample(123, 1'b1);
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample(-5, 1'b0);
        send_sample(7, 1'b0);
    endtask

    // b0 = 0.5 lands exact halves; ties go towards +inf.
    task automatic test_rounding_ties();
        load_coefs(to_q16(0.5), '0, '0, '0, '0);
        send_sample('0, 1'b1);
        send_sample('0, 1'b0);
        send_sample(1, 1'b0);
        send_sample(-1, 1'b0);
        send_sample(3, 1'b0);
        send_sample(-3, 1'b0);
    endtask

    // Coefficient extremes push the sum past both rails.
    task automatic test_saturation_limits();
        load_coefs({1'b0, {(COEF_BITS-1){1'b1}}}, {1'b0, {(COEF_BITS-1){1'b1}}},
                   {1'b0, {(COEF_BITS-1){1'b1}}}, {1'b0, {(COEF_BITS-1){1'b1}}},
                   {1'b0, {(COEF_BITS-1){1'b1}}});
        send_sample(SAMPLE_MAX, 1'b1);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        load_coefs({1'b1, {(COEF_BITS-1){1'b0}}}, {1'b1, {(COEF_BITS-1){1'b0}}},
                   {1'b1, {(COEF_BITS-1){1'b0}}}, {1'b1, {(COEF_BITS-1){1'b0}}},
                   {1'b1, {(COEF_BITS-1){1'b0}}});
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
    endtask

    // Writes past the last coefficient must leave the set untouched.
    task automatic test_unmapped_index();
        int idx;
        load_coefs(to_q16(1.0), '0, '0, '0, '0);
        // let the closing low on config valid land before the next write
        @(posedge i_clk);
        for (idx = NUM_COEFS; idx < CFG_SLOTS; idx++)
            cfg_write(idx[CFG_IDX_BITS-1:0], COEF_BITS'($urandom()));
        i_cfg_valid <= 1'b0;
        send_sample(1000, 1'b1);
        send_sample(-2000, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
    endtask

    // Mostly real Butterworth designs fed random signals, plus raw coefficient noise.
    task automatic test_random_filters();
        int set_no, n;
        for (set_no = 0; set_no < RANDOM_SETS; set_no++) begin
            case (set_no)
                2:       load_coefs(COEF_BITS'($urandom()), COEF_BITS'($urandom()),
                                    COEF_BITS'($urandom()), COEF_BITS'($urandom()),
                                    COEF_BITS'($urandom()));
                3:       load_coefs(COEF_BITS'(int'($urandom_range(0, 65535)) - 32768),
                                    COEF_BITS'(int'($urandom_range(0, 65535)) - 32768),
                                    COEF_BITS'(int'($urandom_range(0, 65535)) - 32768),
                                    COEF_BITS'(int'($urandom_range(0, 65535)) - 32768),
                                    COEF_BITS'(int'($urandom_range(0, 65535)) - 32768));
                default: load_butterworth(0.01 + $urandom_range(0, 400) / 1000.0);
            endcase
            send_sample(pick_sample(), 1'b1);
            for (n = 0; n < SET_BEATS; n++)
                send_sample(pick_sample(), $urandom_range(0, 39) == 0);
        end
    endtask

    // Output side: check each accepted beat, then pick the next stall.
    always @(posedge i_clk) begin : rx_side
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (predicted_outputs.size() == 0) begin
                $error("output beat with nothing owed: sample_out %0d",
                       $signed(o_out_data.sample_out));
                err_count++;
            end else begin
                want = predicted_outputs.pop_front();
                beats_checked++;
                if (o_out_data.saturated === 1'b1)
                    clipped_seen++;
                if (o_out_data.sample_out !== want.sample_out) begin
                    $error("sample_out: expected %0d, got %0d",
                           $signed(want.sample_out), $signed(o_out_data.sample_out));
                    err_count++;
                end
                if (o_out_data.saturated !== want.saturated) begin
                    $error("saturated: expected %0b, got %0b",
                           want.saturated, o_out_data.saturated);
                    err_count++;
                end
            end
        end
        // short stall runs between longer free-flowing stretches
        if (stall_run == 0) begin
            stall_on  = ($urandom_range(0, 2) == 0);
            stall_run = stall_on ? $urandom_range(1, 5) : $urandom_range(1, 30);
        end
        i_out_stall <= stall_on;
        stall_run--;
    end

    initial begin
        filt_coef[REG_B0] = B0_RESET;
        filt_coef[REG_B1] = COEF_ZERO;
        filt_coef[REG_B2] = COEF_ZERO;
        filt_coef[REG_A1] = COEF_ZERO;
        filt_coef[REG_A2] = COEF_ZERO;
        hist_x1   = '0;
        hist_x2   = '0;
        hist_y1   = '0;
        hist_y2   = '0;
        warm_left = WARM_TWO;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_warmup_passthrough();
        test_restart_midstream();
        test_rounding_ties();
        test_saturation_limits();
        test_unmapped_index();
        test_random_filters();
        wait_idle();

        $display("covered %0d beats over %0d coefficient sets, %0d restarts",
                 beats_sent, sets_loaded, restarts_sent);
        $display("%0d output beats checked, %0d of them clipped", beats_checked, clipped_seen);
        if (err_count == 0 && predicted_outputs.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
